@@ src/xmodem_crc_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver assertion macros
// Property wrappers used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH

// Check a property outside reset.
`define XCR_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define XCR_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/xcr_pkg.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Protocol bytes, command and status codes, result types and the CRC step.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int DEST_ADDR_BITS = 16;
    localparam logic [15:0] ADDR_MASK =
        (DEST_ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DEST_ADDR_BITS) - 32'd1);

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [9:0]  CAP_MAX   = 10'd512;
    localparam logic [9:0]  CAP_RESET = 10'd512;
    localparam logic [6:0]  LAST_DATA_INDEX = 7'd127;
    localparam logic [16:0] BLOCK_BYTES = 17'd128;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RECV   = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_CANCEL = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_WAIT   = 8'b0000_0010,
        PH_HDR    = 8'b0000_0100,
        PH_DATA   = 8'b0000_1000,
        PH_CRC    = 8'b0001_0000,
        PH_DONE   = 8'b0010_0000,
        PH_CANCEL = 8'b0100_0000,
        PH_FULL   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
    } entry_t;

    typedef struct packed {
        logic [1:0]  count;
        entry_t [2:0] entries;
        logic [2:0]  status;
        logic [16:0] length;
    } res_set_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ src/xmodem_crc_receiver.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver: packet check, data writes and prompts per input byte.
// First result registered, valid in the cycle after the input is accepted.
// One input per cycle if not stalled; a new input waits for the last result.
// Reset: synchronous active-low aresetn clears state, capacity returns to 512.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], rx_byte[9:2], zero fill[15:10]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_byte[7:0], write_addr[23:8], write_data[31:24], status[34:32],
    // received_length[51:35], zero fill[55:52]
    output logic [55:0] m_tdata,
    // send_valid[0], write_valid[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import xcr_pkg::*;

    logic [9:0]  cap_reg;
    phase_t      phase_reg,    phase_next;
    logic [7:0]  exp_blk_reg,  exp_blk_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [6:0]  index_reg,    index_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_hi_reg,   crc_hi_next;
    logic [16:0] length_reg,   length_next;

    logic [1:0]  cmd;
    logic [7:0]  rx;
    logic        accept;
    logic [9:0]  cap_eff;
    logic [16:0] limit;
    logic [16:0] addr_sum;
    logic [16:0] len_plus;
    res_set_t    res_set;
    entry_t      e_send;

    assign cmd      = s_tdata[1:0];
    assign rx       = s_tdata[9:2];
    assign accept   = s_tvalid && s_tready;
    assign cap_eff  = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign limit    = {cap_eff, 7'b0};
    assign addr_sum = length_reg + {10'b0, index_reg};
    assign len_plus = length_reg + BLOCK_BYTES;

    always_comb begin
        phase_next    = phase_reg;
        exp_blk_next  = exp_blk_reg;
        hdr_good_next = hdr_good_reg;
        index_next    = index_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        length_next   = length_reg;
        res_set       = '0;
        res_set.count = 2'd1;
        e_send        = '0;
        e_send.send_valid = 1'b1;

        case (cmd)
            CMD_START: begin
                exp_blk_next  = 8'd1;
                hdr_good_next = 1'b0;
                index_next    = 7'd0;
                crc_next      = 16'd0;
                crc_hi_next   = 8'd0;
                length_next   = 17'd0;
                if (limit == 17'd0) begin
                    phase_next = PH_FULL;
                    e_send.send_byte   = B_CAN;
                    res_set.entries[0] = e_send;
                    res_set.entries[1] = e_send;
                    res_set.count      = 2'd2;
                end else begin
                    phase_next = PH_WAIT;
                    e_send.send_byte   = B_C;
                    res_set.entries[0] = e_send;
                end
            end
            CMD_TIMEOUT: begin
                if (phase_reg inside {PH_WAIT, PH_HDR, PH_DATA, PH_CRC}) begin
                    phase_next = PH_WAIT;
                    e_send.send_byte   = B_NAK;
                    res_set.entries[0] = e_send;
                end
            end
            CMD_BYTE: begin
                case (phase_reg)
                    PH_WAIT: begin
                        if (rx == B_SOH) begin
                            phase_next    = PH_HDR;
                            hdr_good_next = 1'b1;
                            index_next    = 7'd0;
                        end else if (rx == B_EOT) begin
                            phase_next = PH_DONE;
                            e_send.send_byte   = B_ACK;
                            res_set.entries[0] = e_send;
                        end else if (rx == B_CAN) begin
                            phase_next = PH_CANCEL;
                        end
                    end
                    PH_HDR: begin
                        if (index_reg == 7'd0) begin
                            if (rx != exp_blk_reg) hdr_good_next = 1'b0;
                            index_next = 7'd1;
                        end else begin
                            if (rx != ~exp_blk_reg) hdr_good_next = 1'b0;
                            index_next = 7'd0;
                            crc_next   = 16'd0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (hdr_good_reg) begin
                            res_set.entries[0].write_valid = 1'b1;
                            res_set.entries[0].write_addr  = addr_sum[15:0] & ADDR_MASK;
                            res_set.entries[0].write_data  = rx;
                        end
                        crc_next = crc_byte(crc_reg, rx);
                        if (index_reg == LAST_DATA_INDEX) begin
                            index_next = 7'd0;
                            phase_next = PH_CRC;
                        end else begin
                            index_next = index_reg + 7'd1;
                        end
                    end
                    PH_CRC: begin
                        if (index_reg == 7'd0) begin
                            crc_hi_next = rx;
                            index_next  = 7'd1;
                        end else begin
                            index_next = 7'd0;
                            if (hdr_good_reg && ({crc_hi_reg, rx} == crc_reg)) begin
                                length_next  = len_plus;
                                exp_blk_next = exp_blk_reg + 8'd1;
                                e_send.send_byte   = B_ACK;
                                res_set.entries[0] = e_send;
                                if (len_plus >= limit) begin
                                    phase_next = PH_FULL;
                                    e_send.send_byte   = B_CAN;
                                    res_set.entries[1] = e_send;
                                    res_set.entries[2] = e_send;
                                    res_set.count      = 2'd3;
                                end else begin
                                    phase_next = PH_WAIT;
                                end
                            end else begin
                                phase_next = PH_WAIT;
                                e_send.send_byte   = B_NAK;
                                res_set.entries[0] = e_send;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        case (phase_next)
            PH_IDLE:   res_set.status = ST_IDLE;
            PH_DONE:   res_set.status = ST_DONE;
            PH_CANCEL: res_set.status = ST_CANCEL;
            PH_FULL:   res_set.status = ST_FULL;
            default:   res_set.status = ST_RECV;
        endcase
        res_set.length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            exp_blk_reg  <= 8'd1;
            hdr_good_reg <= 1'b0;
            index_reg    <= 7'd0;
            crc_reg      <= 16'd0;
            crc_hi_reg   <= 8'd0;
            length_reg   <= 17'd0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            exp_blk_reg  <= exp_blk_next;
            hdr_good_reg <= hdr_good_next;
            index_reg    <= index_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            length_reg   <= length_next;
        end
    end

    xcr_out_seq u_out_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res_set  (res_set),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/xcr_out_seq.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver result sequencer
// Holds the result transactions of one input and issues them in order.
// ----------------------------------------------------------------------------
module xcr_out_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  xcr_pkg::res_set_t res_set,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    // send_byte[7:0], write_addr[23:8], write_data[31:24], status[34:32],
    // received_length[51:35], zero fill[55:52]
    output logic [55:0]       m_tdata,
    // send_valid[0], write_valid[1]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import xcr_pkg::*;

    entry_t      entries_reg [3];
    logic [1:0]  count_reg;
    logic [2:0]  status_reg;
    logic [16:0] length_reg;
    logic        pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign m_tlast  = (count_reg == 2'd1);
    assign m_tuser  = {entries_reg[0].write_valid, entries_reg[0].send_valid};
    assign m_tdata  = {4'b0, length_reg, status_reg, entries_reg[0].write_data,
                       entries_reg[0].write_addr, entries_reg[0].send_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load) begin
            count_reg <= res_set.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entries_reg[0] <= res_set.entries[0];
            entries_reg[1] <= res_set.entries[1];
            entries_reg[2] <= res_set.entries[2];
            status_reg     <= res_set.status;
            length_reg     <= res_set.length;
        end else if (pop) begin
            entries_reg[0] <= entries_reg[1];
            entries_reg[1] <= entries_reg[2];
        end
    end

endmodule

@@ src/xcr_checker.sv @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver port checker
// Watches the top-level ports and flags illegal result transactions.
// ----------------------------------------------------------------------------
`include "xmodem_crc_receiver_assert.svh"

module xcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `XCR_ASSERT_RUN(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `XCR_ASSERT_RUN(a_one_kind, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "send and write in one transaction")
    `XCR_ASSERT_RUN(a_write_recv, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tdata[34:32] == 3'd1, "write outside receiving status")
    `XCR_ASSERT_RUN(a_len_block, aclk, aresetn, m_tvalid |-> m_tdata[41:35] == 7'd0, "length not a whole block")
    `XCR_ASSERT_ALL(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

endmodule

bind xmodem_crc_receiver xcr_checker u_xcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
